// ===== hw/rtl/star_centroid_3x3_macros.svh =====
// Assertion macros shared by the star centroid checker.
`ifndef STAR_CENTROID_3X3_MACROS_SVH
`define STAR_CENTROID_3X3_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/scc_pkg.sv =====
// Shared types and constants for the 3x3 star centroid pipeline.
`default_nettype none
package scc_pkg;

  // Number of pixels in one window.
  localparam int NUM_PIX = 9;

  // Result status codes.
  typedef logic [1:0] scc_status_t;
  localparam scc_status_t ST_FOUND    = 2'd0;
  localparam scc_status_t ST_FIT_FAIL = 2'd1;
  localparam scc_status_t ST_REJECT   = 2'd2;

  // Rejection flags that travel with the intersection data.
  typedef struct packed {
    logic fail;
    logic den_zero;
    logic ovf;
    logic neg;
  } scc_flags_t;

endpackage
`default_nettype wire

// ===== hw/rtl/star_centroid_3x3.sv =====
// Top level of the 3x3 star centroid pipeline.
// Throughput: one window per cycle; the pipeline holds while the output waits.
// Most of the depth comes from the two pipelined dividers, one quotient bit per stage each.
// Reset (rst_n low, synchronous) clears every stage valid bit; data regs are not reset.
`default_nettype none
module star_centroid_3x3 #(
  parameter int PIXEL_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // pix_r0_c0, pix_r0_c1, pix_r0_c2, pix_r1_c0, pix_r1_c1, pix_r1_c2,
  // pix_r2_c0, pix_r2_c1, pix_r2_c2, zero fill
  input  logic [((scc_pkg::NUM_PIX*PIXEL_BITS+7)/8)*8-1:0] in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // x_center, y_center, zero fill
  output logic [((2*(FRAC_BITS+2)+7)/8)*8-1:0] out_tdata,
  // status
  output logic [1:0]          out_tuser
);

  localparam int PB    = PIXEL_BITS;
  localparam int FB    = FRAC_BITS;
  localparam int OUT_W = ((2*(FB+2)+7)/8)*8;
  localparam int CTAG  = 1 + $bits(scc_pkg::scc_flags_t) + 2*(FB+2);

  logic adv;
  logic out_valid;

  // The whole pipeline moves whenever the output register is free or being read.
  assign adv       = !out_valid || out_tready;
  assign in_tready = adv;

  // Stage 1: six peak setups, rows first, then columns.
  logic signed [PB-1:0] pix [0:scc_pkg::NUM_PIX-1];
  logic [5:0][PB+1:0]   n_mag, d_mag;
  logic [5:0]           fit_fail;
  logic                 v_fit_r;

  always_comb begin
    for (int i = 0; i < scc_pkg::NUM_PIX; i++) begin
      pix[i] = in_tdata[i*PB +: PB];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_fit
    scc_peak_fit #(.PIXEL_BITS(PB)) u_row (
      .clk(clk), .en(adv),
      .f0_i(pix[3*i]), .f1_i(pix[3*i+1]), .f2_i(pix[3*i+2]),
      .n_mag_r(n_mag[i]), .d_mag_r(d_mag[i]), .fail_r(fit_fail[i])
    );
    scc_peak_fit #(.PIXEL_BITS(PB)) u_col (
      .clk(clk), .en(adv),
      .f0_i(pix[i]), .f1_i(pix[i+3]), .f2_i(pix[i+6]),
      .n_mag_r(n_mag[i+3]), .d_mag_r(d_mag[i+3]), .fail_r(fit_fail[i+3])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_fit_r <= 1'b0;
    end else if (adv) begin
      v_fit_r <= in_tvalid;
    end
  end

  // Peak divisions: trunc(n * 2^FB / d) for all six fits in parallel.
  logic [5:0][PB+FB+1:0] pk_num;
  logic [5:0][FB+1:0]    pk_q;
  logic [5:0]            pk_fail;
  logic                  v_pk;

  always_comb begin
    for (int l = 0; l < 6; l++) begin
      pk_num[l] = {n_mag[l], {FB{1'b0}}};
    end
  end

  scc_div_pipe #(
    .LANES(6), .NB(PB+FB+2), .DB(PB+2), .QB(FB+2), .TAG_W(6)
  ) u_pk_div (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .vld_i(v_fit_r), .tag_i(fit_fail), .num_i(pk_num), .den_i(d_mag),
    .vld_o(v_pk), .tag_o(pk_fail), .quo_o(pk_q)
  );

  // Line fits and intersection terms.
  logic                  v_ln;
  scc_pkg::scc_flags_t   ln_flags;
  logic [FB+2:0]         ln_num;
  logic [FB+1:0]         ln_den, ln_by;
  logic signed [FB+1:0]  ln_my;

  scc_line_fit #(.FRAC_BITS(FB)) u_line (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .v_i(v_pk), .fail_i(|pk_fail),
    .rp0_i(pk_q[0]), .rp1_i(pk_q[1]), .rp2_i(pk_q[2]),
    .cp0_i(pk_q[3]), .cp1_i(pk_q[4]), .cp2_i(pk_q[5]),
    .v_o(v_ln), .flags_o(ln_flags), .num_mag_o(ln_num), .den_o(ln_den),
    .by_o(ln_by), .my_o(ln_my)
  );

  // Centre division: trunc(|num| * 2^FB / den), flags and y terms ride along.
  logic [0:0][2*FB+2:0]  c_num;
  logic [0:0][FB+1:0]    c_den;
  logic [0:0][FB+1:0]    c_q;
  logic [CTAG-1:0]       c_tag_i, c_tag_o;
  logic                  v_c;
  scc_pkg::scc_flags_t   c_flags;
  logic [FB+1:0]         c_by;
  logic signed [FB+1:0]  c_my;
  logic                  c_unused_v;

  assign c_num[0] = {ln_num, {FB{1'b0}}};
  assign c_den[0] = ln_den;
  assign c_tag_i  = {v_ln, ln_flags, ln_by, ln_my};

  scc_div_pipe #(
    .LANES(1), .NB(2*FB+3), .DB(FB+2), .QB(FB+2), .TAG_W(CTAG)
  ) u_c_div (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .vld_i(v_ln), .tag_i(c_tag_i), .num_i(c_num), .den_i(c_den),
    .vld_o(v_c), .tag_o(c_tag_o), .quo_o(c_q)
  );

  assign {c_unused_v, c_flags, c_by, c_my} = c_tag_o;

  // Final checks and output register.
  logic [FB+1:0]        x_out, y_out;
  scc_pkg::scc_status_t st_out;

  scc_finish #(.FRAC_BITS(FB)) u_fin (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .v_i(v_c && c_unused_v), .flags_i(c_flags), .q_i(c_q[0]),
    .by_i(c_by), .my_i(c_my),
    .out_valid_r(out_valid), .x_r(x_out), .y_r(y_out), .status_r(st_out)
  );

  assign out_tvalid = out_valid;
  assign out_tdata  = OUT_W'({y_out, x_out});
  assign out_tuser  = st_out;

endmodule
`default_nettype wire

// ===== hw/rtl/scc_peak_fit.sv =====
// Three-point quadratic peak setup: numerator, curvature and failure test.
`default_nettype none
module scc_peak_fit #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [PIXEL_BITS-1:0] f0_i,
  input  logic signed [PIXEL_BITS-1:0] f1_i,
  input  logic signed [PIXEL_BITS-1:0] f2_i,
  output logic [PIXEL_BITS+1:0]        n_mag_r,
  output logic [PIXEL_BITS+1:0]        d_mag_r,
  output logic                         fail_r
);

  localparam int W = PIXEL_BITS + 4;

  logic signed [W-1:0] e0, e1, e2;
  logic signed [W-1:0] n_c, d_c, nn, dd;
  logic                fail_nxt;

  // Numerator and twice the curvature, sign-normalized so the divisor is positive.
  always_comb begin
    e0 = W'(f0_i);
    e1 = W'(f1_i);
    e2 = W'(f2_i);
    n_c = W'(3 * e0 - 4 * e1 + e2);
    d_c = W'(2 * (e0 - 2 * e1 + e2));
    nn = d_c[W-1] ? -n_c : n_c;
    dd = d_c[W-1] ? -d_c : d_c;
    fail_nxt = (d_c == '0) || nn[W-1] || (nn > (dd <<< 1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_mag_r <= nn[PIXEL_BITS+1:0];
      d_mag_r <= dd[PIXEL_BITS+1:0];
      fail_r  <= fail_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/scc_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes.
`default_nettype none
module scc_div_pipe #(
  parameter int LANES = 1,
  parameter int NB    = 8,
  parameter int DB    = 8,
  parameter int QB    = 4,
  parameter int TAG_W = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         vld_i,
  input  logic [TAG_W-1:0]             tag_i,
  input  logic [LANES-1:0][NB-1:0]     num_i,
  input  logic [LANES-1:0][DB-1:0]     den_i,
  output logic                         vld_o,
  output logic [TAG_W-1:0]             tag_o,
  output logic [LANES-1:0][QB-1:0]     quo_o
);

  logic                     vld_w [0:QB];
  logic [TAG_W-1:0]         tag_w [0:QB];
  logic [LANES-1:0][DB-1:0] rem_w [0:QB];
  logic [LANES-1:0][DB-1:0] den_w [0:QB];
  logic [LANES-1:0][QB-1:0] low_w [0:QB];
  logic [LANES-1:0][QB-1:0] quo_w [0:QB];

  // The upper numerator bits seed the remainder; the rest feed in one per stage.
  always_comb begin
    vld_w[0] = vld_i;
    tag_w[0] = tag_i;
    den_w[0] = den_i;
    quo_w[0] = '0;
    for (int l = 0; l < LANES; l++) begin
      rem_w[0][l] = DB'(num_i[l] >> QB);
      low_w[0][l] = num_i[l][QB-1:0];
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic                     vld_r;
    logic [TAG_W-1:0]         tag_r;
    logic [LANES-1:0][DB-1:0] rem_r, rem_nxt, den_r;
    logic [LANES-1:0][QB-1:0] low_r, quo_r, quo_nxt;
    logic [LANES-1:0][DB:0]   trial, diff;
    logic [LANES-1:0]         ge;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l]   = {rem_w[k][l], low_w[k][l][QB-1-k]};
        diff[l]    = trial[l] - {1'b0, den_w[k][l]};
        ge[l]      = trial[l] >= {1'b0, den_w[k][l]};
        rem_nxt[l] = ge[l] ? diff[l][DB-1:0] : trial[l][DB-1:0];
        quo_nxt[l] = {quo_w[k][l][QB-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r <= tag_w[k];
        rem_r <= rem_nxt;
        den_r <= den_w[k];
        low_r <= low_w[k];
        quo_r <= quo_nxt;
      end
    end

    assign vld_w[k+1] = vld_r;
    assign tag_w[k+1] = tag_r;
    assign rem_w[k+1] = rem_r;
    assign den_w[k+1] = den_r;
    assign low_w[k+1] = low_r;
    assign quo_w[k+1] = quo_r;
  end

  assign vld_o = vld_w[QB];
  assign tag_o = tag_w[QB];
  assign quo_o = quo_w[QB];

endmodule
`default_nettype wire

// ===== hw/rtl/scc_line_fit.sv =====
// Line fits through the row and column peaks and the intersection terms.
`default_nettype none
module scc_line_fit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       v_i,
  input  logic                       fail_i,
  input  logic [FRAC_BITS+1:0]       rp0_i,
  input  logic [FRAC_BITS+1:0]       rp1_i,
  input  logic [FRAC_BITS+1:0]       rp2_i,
  input  logic [FRAC_BITS+1:0]       cp0_i,
  input  logic [FRAC_BITS+1:0]       cp1_i,
  input  logic [FRAC_BITS+1:0]       cp2_i,
  output logic                       v_o,
  output scc_pkg::scc_flags_t        flags_o,
  output logic [FRAC_BITS+2:0]       num_mag_o,
  output logic [FRAC_BITS+1:0]       den_o,
  output logic [FRAC_BITS+1:0]       by_o,
  output logic signed [FRAC_BITS+1:0] my_o
);

  localparam int FB = FRAC_BITS;
  // Reciprocal of three, exact for sums below 2^(FB+3).
  localparam logic [FB+2:0] M3 = (FB+3)'(((1 << (FB + 4)) + 2) / 3);

  // Stage 1: peak sums and half slopes.
  logic [FB+2:0] sx_nxt, sy_nxt;
  logic [FB+2:0] dx, dy, dx_adj, dy_adj;
  logic          v1_r, fail1_r;
  logic [FB+2:0] sx1_r, sy1_r;
  logic [FB+1:0] mx1_r, my1_r;

  always_comb begin
    sx_nxt = (FB+3)'(rp0_i) + (FB+3)'(rp1_i) + (FB+3)'(rp2_i);
    sy_nxt = (FB+3)'(cp0_i) + (FB+3)'(cp1_i) + (FB+3)'(cp2_i);
    dx = {1'b0, rp2_i} - {1'b0, rp0_i};
    dy = {1'b0, cp2_i} - {1'b0, cp0_i};
    // Halving rounds toward zero: add one to negative values before the shift.
    dx_adj = dx + {{(FB+2){1'b0}}, dx[FB+2]};
    dy_adj = dy + {{(FB+2){1'b0}}, dy[FB+2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fail1_r <= fail_i;
      sx1_r   <= sx_nxt;
      sy1_r   <= sy_nxt;
      mx1_r   <= dx_adj[FB+2:1];
      my1_r   <= dy_adj[FB+2:1];
    end
  end

  // Stage 2: multiply the sums by the reciprocal of three.
  logic            v2_r, fail2_r;
  logic [2*FB+5:0] qx2_r, qy2_r;
  logic [FB+1:0]   mx2_r, my2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fail2_r <= fail1_r;
      qx2_r   <= (2*FB+6)'(sx1_r) * (2*FB+6)'(M3);
      qy2_r   <= (2*FB+6)'(sy1_r) * (2*FB+6)'(M3);
      mx2_r   <= mx1_r;
      my2_r   <= my1_r;
    end
  end

  // Stage 3: intercepts and the term by - my - 1.
  logic                     v3_r, fail3_r;
  logic [FB+1:0]            bx3_r, by3_r;
  logic signed [FB+1:0]     mx3_r, my3_r;
  logic [FB+3:0]            t_nxt;
  logic signed [FB+3:0]     t3_r;

  assign t_nxt = {2'b00, qy2_r[2*FB+5:FB+4]} - {{2{my2_r[FB+1]}}, my2_r}
               - {4'b0001, {FB{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fail3_r <= fail2_r;
      bx3_r   <= qx2_r[2*FB+5:FB+4];
      by3_r   <= qy2_r[2*FB+5:FB+4];
      mx3_r   <= mx2_r;
      my3_r   <= my2_r;
      t3_r    <= t_nxt;
    end
  end

  // Stage 4: the two slope products.
  logic                     v4_r, fail4_r;
  logic [FB+1:0]            bx4_r, by4_r;
  logic signed [FB+1:0]     my4_r;
  logic signed [2*FB+5:0]   p1_nxt, p1_4_r;
  logic signed [2*FB+3:0]   p2_nxt, p2_4_r;

  always_comb begin
    p1_nxt = mx3_r * t3_r;
    p2_nxt = mx3_r * my3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fail4_r <= fail3_r;
      bx4_r   <= bx3_r;
      by4_r   <= by3_r;
      my4_r   <= my3_r;
      p1_4_r  <= p1_nxt;
      p2_4_r  <= p2_nxt;
    end
  end

  // Stage 5: numerator and denominator of the intersection, with range checks.
  logic [2*FB+5:0] adj1;
  logic [2*FB+3:0] adj2;
  logic [FB+3:0]   num_c;
  logic [FB+2:0]   q2, den_full;
  logic [FB+2:0]   mag_c;
  logic [FB+1:0]   den_c;
  scc_pkg::scc_flags_t flags_nxt;
  logic            v5_r;

  always_comb begin
    // Division by one in fixed point truncates toward zero.
    adj1     = p1_4_r + {{(FB+6){1'b0}}, {FB{p1_4_r[2*FB+5]}}};
    adj2     = p2_4_r + {{(FB+4){1'b0}}, {FB{p2_4_r[2*FB+3]}}};
    num_c    = adj1[2*FB+3:FB] + {2'b00, bx4_r};
    q2       = adj2[2*FB+2:FB];
    den_full = q2 + {3'b001, {FB{1'b0}}};
    den_c    = den_full[FB+1:0];
    mag_c    = num_c[FB+3] ? (~num_c[FB+2:0] + 1'b1) : num_c[FB+2:0];
    flags_nxt.fail     = fail4_r;
    flags_nxt.den_zero = (den_c == '0);
    flags_nxt.ovf      = {1'b0, mag_c} >= {den_c, 2'b00};
    flags_nxt.neg      = num_c[FB+3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags_o   <= flags_nxt;
      num_mag_o <= mag_c;
      den_o     <= den_c;
      by_o      <= by4_r;
      my_o      <= my4_r;
    end
  end

  assign v_o = v5_r;

endmodule
`default_nettype wire

// ===== hw/rtl/scc_finish.sv =====
// Final centre coordinate checks, status and the output register.
`default_nettype none
module scc_finish #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        v_i,
  input  scc_pkg::scc_flags_t         flags_i,
  input  logic [FRAC_BITS+1:0]        q_i,
  input  logic [FRAC_BITS+1:0]        by_i,
  input  logic signed [FRAC_BITS+1:0] my_i,
  output logic                        out_valid_r,
  output logic [FRAC_BITS+1:0]        x_r,
  output logic [FRAC_BITS+1:0]        y_r,
  output scc_pkg::scc_status_t        status_r
);

  localparam int FB = FRAC_BITS;
  localparam logic [FB+1:0] TWO_FX = {2'b10, {FB{1'b0}}};

  // Stage 1: test x and form (x - 1) * my.
  logic                   xok;
  scc_pkg::scc_status_t   st_nxt, st1_r;
  logic signed [FB+2:0]   xm;
  logic signed [2*FB+4:0] p3_nxt, p3_r;
  logic [FB+1:0]          x1_r, by1_r;
  logic                   v1_r;

  always_comb begin
    xok = !flags_i.den_zero && !flags_i.ovf && !flags_i.neg
          && (q_i != '0) && (q_i <= TWO_FX);
    if (flags_i.fail) begin
      st_nxt = scc_pkg::ST_FIT_FAIL;
    end else if (!xok) begin
      st_nxt = scc_pkg::ST_REJECT;
    end else begin
      st_nxt = scc_pkg::ST_FOUND;
    end
    xm     = {1'b0, q_i} - {3'b001, {FB{1'b0}}};
    p3_nxt = xm * my_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1_r <= st_nxt;
      x1_r  <= q_i;
      by1_r <= by_i;
      p3_r  <= p3_nxt;
    end
  end

  // Stage 2: y, its range check and the registered result.
  logic [2*FB+4:0]      adj3;
  logic [FB+2:0]        q3;
  logic [FB+3:0]        y_c;
  logic                 yok;
  scc_pkg::scc_status_t st2;

  always_comb begin
    adj3 = p3_r + {{(FB+5){1'b0}}, {FB{p3_r[2*FB+4]}}};
    q3   = adj3[2*FB+2:FB];
    y_c  = {q3[FB+2], q3} + {2'b00, by1_r};
    yok  = !y_c[FB+3] && (y_c != '0) && (y_c <= {2'b00, TWO_FX});
    if (st1_r != scc_pkg::ST_FOUND) begin
      st2 = st1_r;
    end else if (yok) begin
      st2 = scc_pkg::ST_FOUND;
    end else begin
      st2 = scc_pkg::ST_REJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v1_r;
    end
  end

  // Rejected windows report zero coordinates.
  always_ff @(posedge clk) begin
    if (en) begin
      status_r <= st2;
      x_r      <= (st2 == scc_pkg::ST_FOUND) ? x1_r : '0;
      y_r      <= (st2 == scc_pkg::ST_FOUND) ? y_c[FB+1:0] : '0;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/scc_checker.sv =====
// Port-level checker for the star centroid block, with its bind statement.
`default_nettype none
`include "star_centroid_3x3_macros.svh"
module scc_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tready,
  input  logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic [((2*(FRAC_BITS+2)+7)/8)*8-1:0]   out_tdata,
  input  logic [1:0]                             out_tuser
);

  localparam int FB = FRAC_BITS;
  localparam logic [FB+1:0] TWO_FX = {2'b10, {FB{1'b0}}};

  logic [FB+1:0] x_c;
  logic          rejected;

  assign x_c      = out_tdata[FB+1:0];
  assign rejected = out_tuser != scc_pkg::ST_FOUND;

  // A waiting result holds its value.
  `SCC_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // Rejected windows carry zero coordinates.
  `SCC_ASSERT_IMP(a_rej_zero, clk, rst_n, out_tvalid && rejected, out_tdata == '0, "rejected result has nonzero coordinates")

  // The x coordinate of a found centre lies in the box and is not zero.
  `SCC_ASSERT_IMP(a_x_box, clk, rst_n, out_tvalid && !rejected, x_c != '0 && x_c <= TWO_FX, "found x outside 0..2")

  // With the output register empty the pipeline takes input.
  `SCC_ASSERT_IMP(a_ready, clk, rst_n, !out_tvalid, in_tready, "input stalled with empty output")

endmodule

bind star_centroid_3x3 scc_checker #(.FRAC_BITS(FRAC_BITS)) u_scc_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tuser(out_tuser)
);
`default_nettype wire
